FILE: hw/rtl/stretch_sensor_frame_parser_core_assert.svh
// Assertion macros used by the frame parser core.
`ifndef STRETCH_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH
`define STRETCH_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ssfp_pkg.sv
// Types, constants and helper functions of the sensor frame parser.
package ssfp_pkg;

    localparam int STORE_DEPTH = 14;
    localparam int COUNT_W     = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 4'd15;
    localparam logic [COUNT_W-1:0] LEN_BINARY    = 4'd6;
    localparam logic [COUNT_W-1:0] LEN_ASCII_CAL = 4'd14;
    localparam logic [COUNT_W-1:0] LEN_ASCII_RAW = 4'd12;
    localparam logic [COUNT_W-1:0] LEN_MEAS_ERR  = 4'd9;

    localparam int          EAP_LEN  = 9;
    localparam logic [71:0] EAP_TEXT = "EAP error";

    localparam logic [15:0] STRETCH_FAIL = 16'h8000;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_KELVIN  = 8'h4B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_PARSE_ERR = 2'd1;
    localparam logic [1:0] ST_CSUM_ERR  = 2'd2;
    localparam logic [1:0] ST_MEAS_FAIL = 2'd3;

    localparam logic [1:0] KIND_BIN_CAL   = 2'd0;
    localparam logic [1:0] KIND_ASCII_CAL = 2'd1;
    localparam logic [1:0] KIND_ASCII_RAW = 2'd2;

    typedef logic [STORE_DEPTH-1:0][7:0] t_frame;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  reading_kind;
        logic [16:0] stretch_hundredths;
        logic [15:0] temperature_tenths;
        logic [15:0] raw_reading;
        logic [7:0]  flag_byte;
    } t_out_item;

    // A byte outside '0'..'9' reads as digit zero.
    function automatic logic [3:0] digit_of(input logic [7:0] b);
        logic [3:0] d;
        d = 4'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = b[3:0];
        end
        return d;
    endfunction

    // Five decimal digits weighted 10000 down to 1.
    function automatic logic [16:0] five_digits(input logic [3:0] d4, input logic [3:0] d3,
                                                input logic [3:0] d2, input logic [3:0] d1,
                                                input logic [3:0] d0);
        return (17'(d4) * 17'd10000) + (17'(d3) * 17'd1000) + (17'(d2) * 17'd100)
               + (17'(d1) * 17'd10) + 17'(d0);
    endfunction

endpackage

FILE: hw/rtl/stretch_sensor_frame_parser_core.sv
// Top level of the sensor frame parser: byte store, length count and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (rx_byte, end_of_message)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (status ... flag_byte)
//
// Every byte is first held in the input register and is stored when it advances from there.
// A byte flagged as last is decoded in that same cycle into the result register,
// so a result is registered as its last byte leaves the input register.
// A byte can be accepted in every cycle; only a last byte waits for a held result.
// Reset clears the count and valid flags; stored bytes are not cleared.
module stretch_sensor_frame_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssfp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssfp_pkg::t_out_item o_out_data
);
    import ssfp_pkg::*;

`include "stretch_sensor_frame_parser_core_assert.svh"

    logic               r_in_valid;
    t_in_item           r_in;
    logic [COUNT_W-1:0] r_count;
    logic [7:0]         r_store [STORE_DEPTH];
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_adv;
    logic               w_decode;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] w_len;
    t_frame             w_frame;
    t_out_item          w_result;

    // A last byte needs the result register free (or emptying this cycle).
    assign w_adv      = r_in_valid && (!r_in.end_of_message || !r_out_valid || i_out_ready);
    assign w_decode   = w_adv && r_in.end_of_message;
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_len = (r_count == COUNT_MAX) ? r_count : r_count + 4'd1;

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            w_frame[i] = (r_count == COUNT_W'(i)) ? r_in.rx_byte : r_store[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_adv) begin
            if (r_in.end_of_message) begin
                n_count = '0;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 4'd1;
            end
        end
    end

    ssfp_decode u_decode (
        .i_frame  (w_frame),
        .i_len    (w_len),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_decode) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv && r_count < COUNT_W'(STORE_DEPTH)) begin
            r_store[r_count] <= r_in.rx_byte;
        end
        if (w_decode) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SSFP_ASSERT_IMP(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(w_decode), "result appeared without a decoded last byte")
    `SSFP_ASSERT_NXT(a_count_cleared, i_clk, i_rst_n, w_decode, r_count == '0, "byte count not cleared after decode")
    `SSFP_ASSERT_IMP(a_error_fields_zero, i_clk, i_rst_n, r_out_valid && r_out.status != ST_SUCCESS, r_out.reading_kind == KIND_BIN_CAL && r_out.flag_byte == '0 && r_out.raw_reading == '0, "error result carries nonzero fields")
    `SSFP_ASSERT_NXT(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid && $stable(r_out), "held result was overwritten")

endmodule

FILE: hw/rtl/ssfp_decode.sv
// End-of-message classifier and value decoder for a complete sensor frame.
module ssfp_decode (
    input  ssfp_pkg::t_frame    i_frame,
    input  logic [3:0]          i_len,
    output ssfp_pkg::t_out_item o_result
);
    import ssfp_pkg::*;

    logic        w_eap_match;
    logic [7:0]  w_csum;
    logic [15:0] w_bin_str;
    logic [15:0] w_bin_temp;
    logic [16:0] w_cal_str;
    logic [16:0] w_raw_cnt;
    logic [16:0] w_cal_temp;
    logic [16:0] w_raw_temp;
    logic        w_cal_sep;
    logic        w_raw_sep;

    always_comb begin
        w_eap_match = 1'b1;
        for (int i = 0; i < EAP_LEN; i++) begin
            if (i_frame[i] != EAP_TEXT[(EAP_LEN-1-i)*8 +: 8]) begin
                w_eap_match = 1'b0;
            end
        end
    end

    assign w_csum     = i_frame[0] + i_frame[1] + i_frame[2] + i_frame[3] + i_frame[4];
    assign w_bin_temp = {i_frame[0], i_frame[1]};
    assign w_bin_str  = {i_frame[2], i_frame[3]};

    assign w_cal_sep = (i_frame[6] == CH_PERCENT) && (i_frame[7] == CH_COMMA)
                       && (i_frame[13] == CH_KELVIN);
    assign w_raw_sep = (i_frame[5] == CH_COMMA) && (i_frame[11] == CH_KELVIN);

    assign w_cal_str = five_digits(digit_of(i_frame[0]), digit_of(i_frame[1]),
                                   digit_of(i_frame[2]), digit_of(i_frame[4]),
                                   digit_of(i_frame[5]));
    assign w_raw_cnt = five_digits(digit_of(i_frame[0]), digit_of(i_frame[1]),
                                   digit_of(i_frame[2]), digit_of(i_frame[3]),
                                   digit_of(i_frame[4]));

    // Temperature "DDD.D": the ten-thousands digit is passed as zero to the five-digit helper.
    assign w_cal_temp = five_digits(4'd0, digit_of(i_frame[8]), digit_of(i_frame[9]),
                                    digit_of(i_frame[10]), digit_of(i_frame[12]));
    assign w_raw_temp = five_digits(4'd0, digit_of(i_frame[6]), digit_of(i_frame[7]),
                                    digit_of(i_frame[8]), digit_of(i_frame[10]));

    always_comb begin
        o_result = '0;
        priority if (i_len == LEN_MEAS_ERR && w_eap_match) begin
            o_result.status = ST_MEAS_FAIL;
        end else if (i_len == LEN_BINARY) begin
            priority if (w_csum != i_frame[5]) begin
                o_result.status = ST_CSUM_ERR;
            end else if (w_bin_str == STRETCH_FAIL) begin
                o_result.status = ST_MEAS_FAIL;
            end else begin
                o_result.status             = ST_SUCCESS;
                o_result.reading_kind       = KIND_BIN_CAL;
                o_result.stretch_hundredths = 17'(w_bin_str);
                o_result.temperature_tenths = w_bin_temp;
                o_result.flag_byte          = i_frame[4];
            end
        end else if (i_len == LEN_ASCII_CAL && w_cal_sep) begin
            o_result.status             = ST_SUCCESS;
            o_result.reading_kind       = KIND_ASCII_CAL;
            o_result.stretch_hundredths = w_cal_str;
            o_result.temperature_tenths = w_cal_temp[15:0];
        end else if (i_len == LEN_ASCII_RAW && w_raw_sep) begin
            o_result.status             = ST_SUCCESS;
            o_result.reading_kind       = KIND_ASCII_RAW;
            o_result.temperature_tenths = w_raw_temp[15:0];
            o_result.raw_reading        = w_raw_cnt[15:0];
        end else begin
            o_result.status = ST_PARSE_ERR;
        end
    end

endmodule

FILE: test/stretch_sensor_frame_parser_core_test.sv
// Self-checking testbench of the sensor frame parser core: random message streams and a scoreboard.
module stretch_sensor_frame_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssfp_pkg::*;

    localparam int          RANDOM_BYTES = 1830;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam logic [7:0]  CH_POINT     = 8'h2E;

    // Predicts one reading per message and checks the block's readings in order.
    class sensor_reading_board;
        logic [7:0]         msg_bytes [STORE_DEPTH];
        logic [COUNT_W-1:0] msg_len;
        t_out_item          pending_readings [$];
        int unsigned        error_count;

        function new();
            msg_len     = '0;
            error_count = 0;
            foreach (msg_bytes[i]) begin
                msg_bytes[i] = '0;
            end
        endfunction

        function int unsigned digit_at(int pos);
            logic [7:0] b;
            b = msg_bytes[pos];
            if (b >= CH_ZERO && b <= CH_NINE) begin
                return b - CH_ZERO;
            end
            return 0;
        endfunction

        // Temperature text "DDD.D" starting at pos, in tenths.
        function int unsigned tenths_at(int pos);
            return digit_at(pos) * 1000 + digit_at(pos + 1) * 100 + digit_at(pos + 2) * 10
                   + digit_at(pos + 4);
        endfunction

        function t_out_item decode_message();
            t_out_item   r;
            logic [7:0]  csum;
            logic [15:0] stretch_word;
            bit          is_eap;
            r = '0;
            is_eap = (msg_len == LEN_MEAS_ERR);
            if (is_eap) begin
                for (int i = 0; i < EAP_LEN; i++) begin
                    if (msg_bytes[i] != EAP_TEXT[8*(EAP_LEN-1-i) +: 8]) begin
                        is_eap = 1'b0;
                    end
                end
            end
            if (is_eap) begin
                r.status = ST_MEAS_FAIL;
            end else if (msg_len == LEN_BINARY) begin
                csum = msg_bytes[0] + msg_bytes[1] + msg_bytes[2] + msg_bytes[3] + msg_bytes[4];
                stretch_word = {msg_bytes[2], msg_bytes[3]};
                if (csum != msg_bytes[5]) begin
                    r.status = ST_CSUM_ERR;
                end else if (stretch_word == STRETCH_FAIL) begin
                    r.status = ST_MEAS_FAIL;
                end else begin
                    r.status             = ST_SUCCESS;
                    r.reading_kind       = KIND_BIN_CAL;
                    r.stretch_hundredths = 17'(stretch_word);
                    r.temperature_tenths = {msg_bytes[0], msg_bytes[1]};
                    r.flag_byte          = msg_bytes[4];
                end
            end else if (msg_len == LEN_ASCII_CAL && msg_bytes[6] == CH_PERCENT
                         && msg_bytes[7] == CH_COMMA && msg_bytes[13] == CH_KELVIN) begin
                r.status             = ST_SUCCESS;
                r.reading_kind       = KIND_ASCII_CAL;
                r.stretch_hundredths = 17'(digit_at(0) * 10000 + digit_at(1) * 1000
                                           + digit_at(2) * 100 + digit_at(4) * 10 + digit_at(5));
                r.temperature_tenths = 16'(tenths_at(8));
            end else if (msg_len == LEN_ASCII_RAW && msg_bytes[5] == CH_COMMA
                         && msg_bytes[11] == CH_KELVIN) begin
                r.status             = ST_SUCCESS;
                r.reading_kind       = KIND_ASCII_RAW;
                r.temperature_tenths = 16'(tenths_at(6));
                r.raw_reading        = 16'(digit_at(0) * 10000 + digit_at(1) * 1000
                                           + digit_at(2) * 100 + digit_at(3) * 10 + digit_at(4));
            end else begin
                r.status = ST_PARSE_ERR;
            end
            return r;
        endfunction

        function void take_byte(t_in_item item);
            if (msg_len < STORE_DEPTH) begin
                msg_bytes[msg_len] = item.rx_byte;
            end
            if (msg_len < COUNT_MAX) begin
                msg_len++;
            end
            if (item.end_of_message) begin
                pending_readings.push_back(decode_message());
                msg_len = '0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (pending_readings.size() == 0) begin
                $error("unexpected reading: status %0d", got.status);
                error_count++;
                return;
            end
            want = pending_readings.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("reading_kind", want.reading_kind, got.reading_kind);
            compare_field("stretch_hundredths", want.stretch_hundredths, got.stretch_hundredths);
            compare_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
            compare_field("raw_reading", want.raw_reading, got.raw_reading);
            compare_field("flag_byte", want.flag_byte, got.flag_byte);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    sensor_reading_board board;
    logic [7:0]          frame_bytes [$];
    int                  tx_idle_pct = 38;
    int                  rx_idle_pct = 84;
    bit                  hold_rx = 1'b0;
    int unsigned         cycle_count = 0;

    stretch_sensor_frame_parser_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= !hold_rx && ($urandom_range(99, 0) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                board.take_byte(in_data);
            end
            if (out_valid && out_ready) begin
                board.check_reading(out_data);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input bit last);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{rx_byte: b, end_of_message: last};
        do begin
            @(posedge clk);
        end while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic load_eap();
        frame_bytes.delete();
        for (int i = 0; i < EAP_LEN; i++) begin
            frame_bytes.push_back(EAP_TEXT[8*(EAP_LEN-1-i) +: 8]);
        end
    endtask

    // Mostly a digit, sometimes any byte, which the block reads as zero unless it is a digit.
    function automatic logic [7:0] digit_char();
        if ($urandom_range(9, 0) == 0) begin
            return 8'($urandom_range(255, 0));
        end
        return CH_ZERO + 8'($urandom_range(9, 0));
    endfunction

    function automatic logic [7:0] point_char();
        if ($urandom_range(3, 0) == 0) begin
            return 8'($urandom_range(255, 0));
        end
        return CH_POINT;
    endfunction

    task automatic break_separator(input int pos, input logic [7:0] sep);
        logic [7:0] b;
        b = 8'($urandom_range(255, 0));
        if (b == sep) begin
            b = ~b;
        end
        frame_bytes[pos] = b;
    endtask

    task automatic build_random_message();
        logic [7:0] csum;
        int         pick;
        int         pos;
        frame_bytes.delete();
        pick = $urandom_range(11, 0);
        case (pick)
            0, 1: begin
                load_eap();
                if (pick == 1) begin
                    pos = $urandom_range(EAP_LEN - 1, 0);
                    frame_bytes[pos] ^= 8'(1 << $urandom_range(7, 0));
                end
            end
            2, 3, 4: begin
                for (int i = 0; i < 5; i++) begin
                    frame_bytes.push_back(8'($urandom_range(255, 0)));
                end
                if ($urandom_range(3, 0) == 0) begin
                    frame_bytes[2] = STRETCH_FAIL[15:8];
                    frame_bytes[3] = STRETCH_FAIL[7:0];
                end
                csum = '0;
                for (int i = 0; i < 5; i++) begin
                    csum += frame_bytes[i];
                end
                if (pick == 4) begin
                    csum += 8'($urandom_range(255, 1));
                end
                frame_bytes.push_back(csum);
            end
            5, 6, 7: begin
                for (int i = 0; i < LEN_ASCII_CAL; i++) begin
                    case (i)
                        3, 11:   frame_bytes.push_back(point_char());
                        6:       frame_bytes.push_back(CH_PERCENT);
                        7:       frame_bytes.push_back(CH_COMMA);
                        13:      frame_bytes.push_back(CH_KELVIN);
                        default: frame_bytes.push_back(digit_char());
                    endcase
                end
                if (pick == 7) begin
                    case ($urandom_range(2, 0))
                        0:       break_separator(6, CH_PERCENT);
                        1:       break_separator(7, CH_COMMA);
                        default: break_separator(13, CH_KELVIN);
                    endcase
                end
            end
            8, 9, 10: begin
                for (int i = 0; i < LEN_ASCII_RAW; i++) begin
                    case (i)
                        9:       frame_bytes.push_back(point_char());
                        5:       frame_bytes.push_back(CH_COMMA);
                        11:      frame_bytes.push_back(CH_KELVIN);
                        default: frame_bytes.push_back(digit_char());
                    endcase
                end
                if (pick == 10) begin
                    if ($urandom_range(1, 0) == 0) begin
                        break_separator(5, CH_COMMA);
                    end else begin
                        break_separator(11, CH_KELVIN);
                    end
                end
            end
            default: begin
                // Noise of 1 to 20 bytes, including messages past the store depth.
                repeat ($urandom_range(20, 1)) begin
                    frame_bytes.push_back(8'($urandom_range(255, 0)));
                end
            end
        endcase
    endtask

    task automatic hold_receiver();
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    initial begin
        int phase_bytes;
        board = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        load_eap();
        send_frame();
        frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB};
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h80};
        send_frame();
        frame_bytes = '{8'h00};
        send_frame();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 84;
                end
                1: begin
                    tx_idle_pct = 84;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // The receiver stalls while bytes keep coming, so the block backs up.
                    fork
                        hold_receiver();
                    join_none
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < RANDOM_BYTES / 3) begin
                build_random_message();
                phase_bytes += frame_bytes.size();
                send_frame();
            end
        end
        in_valid <= 1'b0;

        while (board.pending_readings.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (board.error_count == 0 && board.pending_readings.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
